// ===== rtl/ordered_list_table_engine_macros.svh =====
// assertion macros for the ordered list engine
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ORDERED_LIST_TABLE_ENGINE_MACROS_SVH
`define ORDERED_LIST_TABLE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define OLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define OLE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define OLE_ASSERT(lbl, prop, msg)
`define OLE_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== rtl/ole_pkg.sv =====
// shared types and constants for the ordered list engine
// no dependencies
`timescale 1ns / 1ps

package ole_pkg;

  // default list depth
  localparam int unsigned DEPTH_DEF = 64;

  // fixed field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TAIL = 3'd0,
    OP_POP_TAIL  = 3'd1,
    OP_PUSH_HEAD = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_INSERT    = 3'd4,
    OP_ERASE     = 3'd5,
    OP_FIND      = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_BADPOS   = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_DOWN,
    S_SCAN
  } state_e;

  // walk mode of the datapath read pointer
  typedef enum logic [1:0] {
    MODE_UP,
    MODE_DN,
    MODE_SCAN
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    init;
    logic    issue;
    logic    wr_shift;
    logic    wr_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    done;
    logic    hit;
    mode_e   mode;
    status_e status;
  } ole_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_gt;
    logic pos_ge;
    logic more;
    logic pend;
    logic match;
  } ole_stat_t;

endpackage

// ===== rtl/ordered_list_table_engine.sv =====
// ordered list engine: one request at a time, result strobed on done_o
// push/pop tail and full, empty or bad position results are decided in the execute state
// insert, push head, erase, pop head: execute state, then a shift of the entries moved
// find: execute state, then a scan from index 0 that stops at the first match or at the count
// throughput: busy_o low again in the cycle done_o shows; results cannot be held off
// reset (rst_ni low, asynchronous): count zero, idle; store contents undefined until written
`timescale 1ns / 1ps
`include "ordered_list_table_engine_macros.svh"

module ordered_list_table_engine #(
  parameter int unsigned DEPTH = ole_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request side
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ole_pkg::OP_W-1:0]          op_i,
  input  logic signed [ole_pkg::VAL_W-1:0]  value_i,
  input  logic [ole_pkg::POS_W-1:0]         position_i,
  // result side
  output logic                              done_o,
  output logic [ole_pkg::STAT_W-1:0]        status_o,
  output logic [ole_pkg::IDX_W-1:0]         found_index_o,
  output logic [ole_pkg::CNT_W-1:0]         count_o
);

  import ole_pkg::*;

  // command and status between sequencer and datapath
  ole_cmd_t  cmd;
  ole_stat_t stat;

  // sequencer: decodes the request and steps through shifts and scans
  ole_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // datapath: request registers, entry count, read pointer and the list store
  ole_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .count_o       (count_o)
  );

  // a taken request always makes the block busy in the next cycle
  `OLE_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o, "request taken but block not busy")
  // a request is taken only while idle and is decided in the execute state, so strobes never touch
  `OLE_ASSERT(a_done_gap, done_o |=> !done_o, "result strobes in adjacent cycles")
  // the single store write port never sees a shift and a new value together
  `OLE_ASSERT_NEVER(a_wr_port, cmd.wr_shift && cmd.wr_val, "two writes to the store at once")
  // the count moves by at most one per request
  `OLE_ASSERT_NEVER(a_cnt_step, cmd.cnt_inc && cmd.cnt_dec, "count raised and lowered together")

endmodule

// ===== rtl/ole_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ole_ctrl.sv =====
// sequencing state machine of the ordered list engine
// depends on ole_pkg
`timescale 1ns / 1ps

module ole_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ole_pkg::ole_stat_t stat_i,
  output ole_pkg::ole_cmd_t  cmd_o,
  output logic               busy_o
);

  import ole_pkg::*;

  state_e   state_q, state_d;
  ole_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    cmd.mode   = MODE_UP;
    cmd.status = STAT_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (stat_i.op)
          OP_PUSH_TAIL: begin
            cmd.done = 1'b1;
            if (stat_i.full) begin
              cmd.status = STAT_FULL;
            end else begin
              cmd.wr_val  = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end
          OP_POP_TAIL: begin
            cmd.done = 1'b1;
            if (stat_i.empty) begin
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          OP_PUSH_HEAD: begin
            if (stat_i.full) begin
              cmd.done   = 1'b1;
              cmd.status = STAT_FULL;
            end else begin
              cmd.init = 1'b1;
              state_d  = S_UP;
            end
          end
          OP_POP_HEAD: begin
            cmd.mode = MODE_DN;
            if (stat_i.empty) begin
              cmd.done   = 1'b1;
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.init = 1'b1;
              state_d  = S_DOWN;
            end
          end
          OP_INSERT: begin
            priority if (stat_i.pos_gt) begin
              cmd.done   = 1'b1;
              cmd.status = STAT_BADPOS;
            end else if (stat_i.full) begin
              cmd.done   = 1'b1;
              cmd.status = STAT_FULL;
            end else begin
              cmd.init = 1'b1;
              state_d  = S_UP;
            end
          end
          OP_ERASE: begin
            cmd.mode = MODE_DN;
            if (stat_i.pos_ge) begin
              cmd.done   = 1'b1;
              cmd.status = STAT_BADPOS;
            end else begin
              cmd.init = 1'b1;
              state_d  = S_DOWN;
            end
          end
          OP_FIND: begin
            cmd.mode = MODE_SCAN;
            cmd.init = 1'b1;
            state_d  = S_SCAN;
          end
          default: begin
            cmd.done = 1'b1;
          end
        endcase
      end
      S_UP: begin
        cmd.mode     = MODE_UP;
        cmd.wr_shift = stat_i.pend;
        cmd.issue    = stat_i.more;
        if (!stat_i.more && !stat_i.pend) begin
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.done    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DOWN: begin
        cmd.mode     = MODE_DN;
        cmd.wr_shift = stat_i.pend;
        cmd.issue    = stat_i.more;
        if (!stat_i.more && !stat_i.pend) begin
          cmd.cnt_dec = 1'b1;
          cmd.done    = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.mode = MODE_SCAN;
        priority if (stat_i.pend && stat_i.match) begin
          cmd.hit  = 1'b1;
          cmd.done = 1'b1;
          state_d  = S_IDLE;
        end else if (stat_i.more) begin
          cmd.issue = 1'b1;
        end else if (!stat_i.pend) begin
          cmd.done   = 1'b1;
          cmd.status = STAT_NOTFOUND;
          state_d    = S_IDLE;
        end else begin
          // last read still in flight
          state_d = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/ole_dpath.sv =====
// datapath of the ordered list engine: request registers, count, pointers, store
// depends on ole_pkg and ole_ram
`timescale 1ns / 1ps

module ole_dpath #(
  parameter int unsigned DEPTH = ole_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ole_pkg::ole_cmd_t                 cmd_i,
  output ole_pkg::ole_stat_t                stat_o,
  input  logic [ole_pkg::OP_W-1:0]          op_i,
  input  logic signed [ole_pkg::VAL_W-1:0]  value_i,
  input  logic [ole_pkg::POS_W-1:0]         position_i,
  output logic                              done_o,
  output logic [ole_pkg::STAT_W-1:0]        status_o,
  output logic [ole_pkg::IDX_W-1:0]         found_index_o,
  output logic [ole_pkg::CNT_W-1:0]         count_o
);

  import ole_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned FW = (AW > IDX_W) ? AW : IDX_W;
  localparam int unsigned OW = (CW > CNT_W) ? CW : CNT_W;

  op_e                     op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [POS_W-1:0]        pos_q;
  logic [CW-1:0]           at_q, at_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           rptr_q, rptr_d;
  logic [AW-1:0]           rprev_q, rprev_d;
  logic [CW-1:0]           rem_q, rem_d;
  logic                    pend_q, pend_d;

  logic                    res_valid_q;
  logic [STAT_W-1:0]       res_status_q;
  logic [IDX_W-1:0]        res_found_q;
  logic [CNT_W-1:0]        res_count_q;

  logic [XW-1:0]           pos_in_ext;
  logic [CW-1:0]           cnt_m1, at_p1;
  logic [FW-1:0]           rprev_ext;
  logic [OW-1:0]           cnt_ext;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic [VAL_W-1:0]        ram_rdata;

  assign pos_in_ext = XW'(position_i);
  assign cnt_m1     = count_q - CW'(1);
  assign at_p1      = at_q + CW'(1);
  assign rprev_ext  = FW'(rprev_q);

  // target position latched with the request
  always_comb begin
    unique case (op_e'(op_i))
      OP_PUSH_TAIL:             at_d = count_q;
      OP_PUSH_HEAD, OP_POP_HEAD: at_d = '0;
      default:                  at_d = pos_in_ext[CW-1:0];
    endcase
  end

  // read pointer walk
  always_comb begin
    rptr_d  = rptr_q;
    rprev_d = rprev_q;
    rem_d   = rem_q;
    pend_d  = 1'b0;
    if (cmd_i.init) begin
      unique case (cmd_i.mode)
        MODE_UP: begin
          rptr_d = cnt_m1[AW-1:0];
          rem_d  = count_q - at_q;
        end
        MODE_DN: begin
          rptr_d = at_p1[AW-1:0];
          rem_d  = cnt_m1 - at_q;
        end
        default: begin
          rptr_d = '0;
          rem_d  = count_q;
        end
      endcase
    end else if (cmd_i.issue) begin
      rprev_d = rptr_q;
      rem_d   = rem_q - CW'(1);
      pend_d  = 1'b1;
      if (cmd_i.mode == MODE_UP) begin
        rptr_d = rptr_q - AW'(1);
      end else begin
        rptr_d = rptr_q + AW'(1);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // store write port: shifted entry or new value
  always_comb begin
    ram_we = cmd_i.wr_shift || cmd_i.wr_val;
    if (cmd_i.wr_val) begin
      ram_waddr = at_q[AW-1:0];
      ram_wdata = val_q;
    end else begin
      ram_wdata = ram_rdata;
      if (cmd_i.mode == MODE_UP) begin
        ram_waddr = rprev_q + AW'(1);
      end else begin
        ram_waddr = rprev_q - AW'(1);
      end
    end
  end

  ole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      res_valid_q <= cmd_i.done;
    end
  end

  assign cnt_ext = OW'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      val_q <= value_i;
      pos_q <= position_i;
      at_q  <= at_d;
    end
    rptr_q  <= rptr_d;
    rprev_q <= rprev_d;
    rem_q   <= rem_d;
    if (cmd_i.done) begin
      res_status_q <= cmd_i.status;
      res_found_q  <= cmd_i.hit ? rprev_ext[IDX_W-1:0] : '0;
      res_count_q  <= cnt_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    stat_o        = '0;
    stat_o.op     = op_q;
    stat_o.full   = (count_q == CW'(DEPTH));
    stat_o.empty  = (count_q == '0);
    stat_o.pos_gt = (XW'(pos_q) > XW'(count_q));
    stat_o.pos_ge = (XW'(pos_q) >= XW'(count_q));
    stat_o.more   = (rem_q != '0);
    stat_o.pend   = pend_q;
    stat_o.match  = (ram_rdata == val_q);
  end

  assign done_o        = res_valid_q;
  assign status_o      = res_status_q;
  assign found_index_o = res_found_q;
  assign count_o       = res_count_q;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the ordered list engine: directed corner requests,
// then biased random fill/drain/mixed traffic with a list model kept alongside
// depends on rtl/ole_pkg.sv and rtl/ordered_list_table_engine.sv
`timescale 1ns / 1ps

module tb;
  import ole_pkg::*;

  localparam int unsigned LIST_DEPTH      = DEPTH_DEF;
  localparam int unsigned RANDOM_REQUESTS = 1100;
  // longest request is a full shift or scan of the list, plus the largest gap between requests
  localparam int unsigned IDLE_LIMIT      = 1000;
  localparam int unsigned DRAIN_CYCLES    = 2 * LIST_DEPTH;
  localparam int unsigned MAX_PRINTED     = 100;

  // op code outside the defined set, the engine must ignore it
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // traffic bias of a random burst
  localparam int unsigned BIAS_FILL  = 0;
  localparam int unsigned BIAS_DRAIN = 1;
  localparam int unsigned BIAS_MIXED = 2;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    int unsigned      gap;
  } list_request_t;

  typedef struct {
    status_e          status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] count;
  } list_result_t;

  // chance of each op code (push tail .. find, then the unused code) per bias, in percent
  int unsigned op_weight [3][8] = '{
    '{30,  4, 20,  4, 27,  4, 10, 1},
    '{ 5, 25,  5, 25,  5, 25,  9, 1},
    '{14, 14, 14, 14, 14, 14, 15, 1}
  };

  // dut ports, every input known from time zero
  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    start_i    = 1'b0;
  logic [OP_W-1:0]         op_i       = '0;
  logic signed [VAL_W-1:0] value_i    = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic [STAT_W-1:0]       status_o;
  logic [IDX_W-1:0]        found_index_o;
  logic [CNT_W-1:0]        count_o;

  // stimulus side
  list_request_t    pending_requests [$];
  logic [VAL_W-1:0] value_pool [16];
  int unsigned      gen_fill;
  int unsigned      gap_left;
  logic             req_taken;
  logic             hold_start;
  list_request_t    next_req;

  // prediction and checking side
  logic [VAL_W-1:0] shadow_list [$];
  list_result_t     expected_results [$];
  list_result_t     oldest;
  int unsigned      n_requests;
  int unsigned      n_results;
  int unsigned      n_mismatches;
  int unsigned      idle_cycles;
  int unsigned      peak_fill;
  int unsigned      status_tally [5];

  ordered_list_table_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .count_o       (count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // reset held low at start, released away from the sampling edge
  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    if (n_mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    n_mismatches++;
  endtask

  // apply one request to the shadow list and return the result it should give
  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [VAL_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t res;
    res.status      = STAT_OK;
    res.found_index = '0;
    case (op)
      OP_PUSH_TAIL: begin
        if (shadow_list.size() >= LIST_DEPTH) res.status = STAT_FULL;
        else shadow_list.push_back(val);
      end
      OP_POP_TAIL: begin
        if (shadow_list.size() == 0) res.status = STAT_EMPTY;
        else void'(shadow_list.pop_back());
      end
      OP_PUSH_HEAD: begin
        if (shadow_list.size() >= LIST_DEPTH) res.status = STAT_FULL;
        else shadow_list.push_front(val);
      end
      OP_POP_HEAD: begin
        if (shadow_list.size() == 0) res.status = STAT_EMPTY;
        else void'(shadow_list.pop_front());
      end
      OP_INSERT: begin
        // position check wins over the full check
        if (int'(pos) > shadow_list.size()) res.status = STAT_BADPOS;
        else if (shadow_list.size() >= LIST_DEPTH) res.status = STAT_FULL;
        else shadow_list.insert(int'(pos), val);
      end
      OP_ERASE: begin
        if (int'(pos) >= shadow_list.size()) res.status = STAT_BADPOS;
        else shadow_list.delete(int'(pos));
      end
      OP_FIND: begin
        res.status = STAT_NOTFOUND;
        for (int k = 0; k < shadow_list.size(); k++) begin
          if (shadow_list[k] == val) begin
            res.status      = STAT_OK;
            res.found_index = IDX_W'(k);
            break;
          end
        end
      end
      default: ;  // unused code leaves the list alone
    endcase
    res.count = CNT_W'(shadow_list.size());
    return res;
  endfunction

  // queue a request for the driver; keeps a running fill level so positions can be aimed
  task automatic queue_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                               input logic [POS_W-1:0] pos, input int unsigned gap);
    list_request_t req;
    req.op    = op;
    req.value = val;
    req.pos   = pos;
    req.gap   = gap;
    pending_requests.push_back(req);
    case (op)
      OP_PUSH_TAIL, OP_PUSH_HEAD: if (gen_fill < LIST_DEPTH) gen_fill++;
      OP_POP_TAIL, OP_POP_HEAD:   if (gen_fill > 0) gen_fill--;
      OP_INSERT: if (pos <= gen_fill && gen_fill < LIST_DEPTH) gen_fill++;
      OP_ERASE:  if (pos < gen_fill) gen_fill--;
      default: ;
    endcase
  endtask

  // mostly values from a small pool so finds hit and duplicates occur
  function automatic logic [VAL_W-1:0] draw_value();
    if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents requests at the falling edge, start held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    hold_start = start_i && !req_taken;
    if (start_i && req_taken) begin
      gap_left = (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
    end
    if (!hold_start && rst_ni) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_requests.size() != 0) begin
        next_req   = pending_requests.pop_front();
        hold_start = 1'b1;
        op_i       <= next_req.op;
        value_i    <= next_req.value;
        position_i <= next_req.pos;
      end
    end
    start_i <= hold_start;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each strobed result, then predicts any request taken this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start_i && !busy_o;
      if (done_o) begin
        n_results++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: status %0d count %0d",
                                    status_o, count_o));
        end else begin
          oldest = expected_results.pop_front();
          if (status_o !== oldest.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, oldest.status));
          if (found_index_o !== oldest.found_index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      found_index_o, oldest.found_index));
          if (count_o !== oldest.count)
            report_mismatch($sformatf("count %0d, expected %0d", count_o, oldest.count));
        end
      end
      if (start_i && !busy_o) begin
        n_requests++;
        oldest = apply_request(op_i, value_i, position_i);
        status_tally[oldest.status]++;
        if (shadow_list.size() > peak_fill) peak_fill = shadow_list.size();
        expected_results.push_back(oldest);
      end
    end
  end

  // watchdog on cycles in which neither a request nor a result moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus build and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned      n_random;
    int unsigned      bias;
    int unsigned      burst_len;
    int unsigned      overshoot;
    int unsigned      extra;
    int unsigned      r;
    int unsigned      acc;
    bit               no_gaps;
    bit               burst_over;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;

    gen_fill = 0;
    gap_left = 0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int k = 5; k < 16; k++) value_pool[k] = $urandom;

    // directed corners, starting from an empty list
    queue_request(OP_POP_TAIL,  '0,           '0,      $urandom_range(0, 12));
    queue_request(OP_POP_HEAD,  '0,           '0,      $urandom_range(0, 12));
    queue_request(OP_ERASE,     '0,           '0,      $urandom_range(0, 12));
    queue_request(OP_FIND,      32'h0,        '0,      $urandom_range(0, 12));
    queue_request(OP_INSERT,    32'h5,        7'd1,    $urandom_range(0, 12));
    queue_request(OP_INSERT,    32'h8000_0000, 7'd0,   $urandom_range(0, 12));
    queue_request(OP_PUSH_TAIL, 32'h7fff_ffff, 7'd64,  $urandom_range(0, 12));
    queue_request(OP_PUSH_HEAD, 32'h0,        7'd127 & 7'd64, 0);
    // insert at the count appends at the tail
    queue_request(OP_INSERT,    32'hffff_ffff, 7'd3,   0);
    queue_request(OP_INSERT,    32'h1,        7'd64,   $urandom_range(0, 12));
    queue_request(OP_INSERT,    32'h1,        7'd1,    0);
    queue_request(OP_FIND,      32'hffff_ffff, '0,     $urandom_range(0, 12));
    queue_request(OP_FIND,      32'h7fff_ffff, '0,     0);
    queue_request(OP_FIND,      32'h0000_3039, '0,     0);
    queue_request(OP_ERASE,     '0,           7'd64,   $urandom_range(0, 12));
    queue_request(OP_ERASE,     '0,           7'd5,    0);
    queue_request(OP_ERASE,     '0,           7'd2,    0);
    queue_request(OP_UNUSED,    32'h1234_5678, 7'd0,   $urandom_range(0, 12));
    queue_request(OP_POP_HEAD,  '0,           '0,      0);
    queue_request(OP_POP_TAIL,  '0,           '0,      0);
    // duplicate value, find must give the first index
    queue_request(OP_PUSH_TAIL, 32'h1,        '0,      $urandom_range(0, 12));
    queue_request(OP_FIND,      32'h1,        '0,      0);
    queue_request(OP_FIND,      32'h8000_0000, '0,     0);

    // random bursts: fill to full and beyond, drain to empty and beyond, or mixed
    n_random = 0;
    while (n_random < RANDOM_REQUESTS) begin
      bias       = $urandom_range(BIAS_FILL, BIAS_MIXED);
      burst_len  = $urandom_range(20, 80);
      overshoot  = $urandom_range(2, 8);
      no_gaps    = ($urandom_range(0, 3) == 0);
      extra      = 0;
      burst_over = 1'b0;
      for (int k = 0; k < 300 && !burst_over; k++) begin
        r   = $urandom_range(0, 99);
        acc = 0;
        op  = OP_UNUSED;
        for (int j = 0; j < 8; j++) begin
          acc += op_weight[bias][j];
          if (r < acc) begin
            op = OP_W'(j);
            break;
          end
        end
        // aim insert and erase at legal positions most of the time
        if (op == OP_INSERT && $urandom_range(0, 99) < 85)
          pos = POS_W'($urandom_range(0, gen_fill));
        else if (op == OP_ERASE && gen_fill != 0 && $urandom_range(0, 99) < 85)
          pos = POS_W'($urandom_range(0, gen_fill - 1));
        else
          pos = POS_W'($urandom_range(0, LIST_DEPTH));
        queue_request(op, draw_value(), pos, no_gaps ? 0 : $urandom_range(0, 12));
        n_random++;
        case (bias)
          BIAS_FILL: begin
            if (gen_fill == LIST_DEPTH) extra++;
            burst_over = (extra > overshoot);
          end
          BIAS_DRAIN: begin
            if (gen_fill == 0) extra++;
            burst_over = (extra > overshoot);
          end
          default: burst_over = (k + 1 >= burst_len);
        endcase
      end
    end

    // wait for every request to be taken and every result to come back
    while (pending_requests.size() != 0 || start_i || !rst_ni) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d results checked, list peaked at %0d of %0d entries",
             n_requests, n_results, peak_fill, LIST_DEPTH);
    $display("outcomes ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
             status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_EMPTY],
             status_tally[STAT_BADPOS], status_tally[STAT_NOTFOUND]);
    if (n_mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ole_ctrl.sv
rtl/ole_dpath.sv
rtl/ordered_list_table_engine.sv
dv/tb.sv
